/* sv/latmf_pkg.sv */
// ----------------------------------------------------------------------------
// latmf_pkg: shared types and constants of the LATM audio unit framer
// Payload structs, configuration record, bit command record, header fields.
// ----------------------------------------------------------------------------
package latmf_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] au_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_end;
    } out_item_t;

    typedef struct packed {
        logic       sbr_enabled;
        logic [3:0] core_rate_index;
        logic [3:0] channel_config;
        logic [3:0] extension_rate_index;
    } cfg_t;

    // one bit toward the byte packer, or a pad-and-close request
    typedef struct packed {
        logic vld;
        logic dat;
        logic mark;   // completing this byte ends the transfer run of the item
        logic flush;  // zero-pad the pending bits and close the frame
    } bit_cmd_t;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SBR_ENABLED   = 2'd0;
    localparam logic [1:0] REG_CORE_RATE     = 2'd1;
    localparam logic [1:0] REG_CHANNEL_CFG   = 2'd2;
    localparam logic [1:0] REG_EXT_RATE      = 2'd3;
    localparam int         PADDR_W           = 4;

    localparam cfg_t CFG_RESET = '{
        sbr_enabled:          1'b0,
        core_rate_index:      4'd5,
        channel_config:       4'd1,
        extension_rate_index: 4'd5
    };

    // header fields
    localparam logic [10:0] SYNC_WORD      = 11'h2B7;
    localparam logic [15:0] STREAM_MUX_CFG = 16'h2000; // sameMux 0, ver 0, sameTime 1, rest 0
    localparam logic [4:0]  AOT_LC         = 5'b00010;
    localparam logic [4:0]  AOT_SBR        = 5'b00101;
    localparam logic [2:0]  FRAME_LEN_960  = 3'b100;
    localparam logic [12:0] FRAME_TAIL     = 13'h03FC; // lenType 0, fullness 0xFF, no other, no crc
    localparam logic [7:0]  PLI_RUN_BYTE   = 8'hFF;
    localparam logic [11:0] PLI_RUN        = 12'd255;
    localparam logic [11:0] MAX_UNIT_BYTES = 12'd4095;

    localparam int          HDR_W          = 78;
    localparam logic [6:0]  HDR_BITS_LC    = 7'd69;
    localparam logic [6:0]  HDR_BITS_SBR   = 7'd78;
    // audioMuxLengthBytes = (unit bytes - 1) + runs + offset
    localparam logic [12:0] MUX_OFS_LC     = 13'd8;
    localparam logic [12:0] MUX_OFS_SBR    = 13'd9;
    localparam int          RUNS_W         = 5;

endpackage

/* sv/latmf_byte_pack.sv */
// ----------------------------------------------------------------------------
// latmf_byte_pack: serial bit to byte packer
// Shifts in one bit per cycle MSB first; a bit or pad that completes a byte
// waits for a free output register, which parts it from the downstream stall.
// ----------------------------------------------------------------------------
module latmf_byte_pack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  latmf_pkg::bit_cmd_t  cmd,
    output logic                 cmd_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output latmf_pkg::out_item_t m_data
);

    logic [7:0]           sr_reg, sr_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 ov_reg, ov_next;
    latmf_pkg::out_item_t od_reg, od_next;
    logic                 out_free;
    logic                 complete;
    logic                 take;
    logic [2:0]           pad_shift;

    assign out_free  = !ov_reg || m_ready;
    assign complete  = cmd.flush || (cnt_reg == 3'd7);
    assign cmd_ready = !complete || out_free;
    assign take      = cmd.vld && cmd_ready;
    assign pad_shift = 3'd0 - cnt_reg;  // 8 - pending count

    always_comb begin
        sr_next  = sr_reg;
        cnt_next = cnt_reg;
        ov_next  = ov_reg && !m_ready;
        od_next  = od_reg;
        if (take) begin
            if (cmd.flush) begin
                cnt_next          = 3'd0;
                od_next.out_byte  = sr_reg << pad_shift;
                od_next.frame_end = 1'b1;
                od_next.run_end   = 1'b1;
                ov_next           = 1'b1;
            end else begin
                sr_next  = {sr_reg[6:0], cmd.dat};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    od_next.out_byte  = sr_next;
                    od_next.frame_end = 1'b0;
                    od_next.run_end   = cmd.mark;
                    ov_next           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg <= sr_next;
        od_reg <= od_next;
    end

    assign m_valid = ov_reg;
    assign m_data  = od_reg;

    a_flush_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.vld && cmd.flush |-> cnt_reg != 3'd0)
        else $error("pad request with no pending bits");

    a_frame_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && od_reg.frame_end |-> od_reg.run_end)
        else $error("frame end without run end");

    a_output_held: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !m_ready |=> ov_reg && $stable(od_reg))
        else $error("output transfer changed while stalled");

endmodule

/* sv/latmf_bit_seq.sv */
// ----------------------------------------------------------------------------
// latmf_bit_seq: frame sequencer
// Splits unit length into 255-runs, loads the header shift register, streams
// header, PayloadLengthInfo and payload one bit per ready cycle, then pads.
// ----------------------------------------------------------------------------
module latmf_bit_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  latmf_pkg::cfg_t     cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  latmf_pkg::in_item_t s_data,
    output latmf_pkg::bit_cmd_t cmd,
    input  logic                cmd_ready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_HDR   = 3'd2;
    localparam logic [2:0] ST_PLI   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [11:0]                   rem_reg, rem_next;
    logic [latmf_pkg::RUNS_W-1:0]  runs_reg, runs_next;
    logic [6:0]                    bcnt_reg, bcnt_next;
    logic [11:0]                   rmd_reg, rmd_next;
    logic [latmf_pkg::HDR_W-1:0]   hdr_reg, hdr_next;
    logic [7:0]                    byte_reg, byte_next;
    logic [7:0]                    data_reg, data_next;
    logic [11:0]                   len_in;
    logic [12:0]                   mux_len;
    logic [latmf_pkg::HDR_W-1:0]   hdr_lc, hdr_sbr;

    assign len_in = (s_data.au_length == 12'd0) ? 12'd1 :
                    (s_data.au_length > latmf_pkg::MAX_UNIT_BYTES) ?
                    latmf_pkg::MAX_UNIT_BYTES : s_data.au_length;

    assign mux_len = {1'b0, rem_reg} + {{(13 - latmf_pkg::RUNS_W){1'b0}}, runs_reg} +
                     (cfg.sbr_enabled ? latmf_pkg::MUX_OFS_SBR : latmf_pkg::MUX_OFS_LC);

    assign hdr_lc = {latmf_pkg::SYNC_WORD, mux_len, latmf_pkg::STREAM_MUX_CFG,
                     latmf_pkg::AOT_LC, cfg.core_rate_index, cfg.channel_config,
                     latmf_pkg::FRAME_LEN_960, latmf_pkg::FRAME_TAIL, 9'd0};
    assign hdr_sbr = {latmf_pkg::SYNC_WORD, mux_len, latmf_pkg::STREAM_MUX_CFG,
                      latmf_pkg::AOT_SBR, cfg.core_rate_index, cfg.channel_config,
                      cfg.extension_rate_index, latmf_pkg::AOT_LC,
                      latmf_pkg::FRAME_LEN_960, latmf_pkg::FRAME_TAIL};

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        runs_next  = runs_reg;
        bcnt_next  = bcnt_reg;
        rmd_next   = rmd_reg;
        hdr_next   = hdr_reg;
        byte_next  = byte_reg;
        data_next  = data_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    data_next = s_data.data_byte;
                    if (rem_reg == 12'd0) begin
                        rem_next   = len_in - 12'd1;
                        rmd_next   = len_in;
                        runs_next  = '0;
                        state_next = ST_DIV;
                    end else begin
                        rem_next   = rem_reg - 12'd1;
                        byte_next  = s_data.data_byte;
                        bcnt_next  = 7'd7;
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DIV: begin
                // one subtraction of 255 per cycle
                if (rmd_reg >= latmf_pkg::PLI_RUN) begin
                    rmd_next  = rmd_reg - latmf_pkg::PLI_RUN;
                    runs_next = runs_reg + 1'b1;
                end else begin
                    hdr_next   = cfg.sbr_enabled ? hdr_sbr : hdr_lc;
                    bcnt_next  = (cfg.sbr_enabled ? latmf_pkg::HDR_BITS_SBR :
                                  latmf_pkg::HDR_BITS_LC) - 7'd1;
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                cmd.vld = 1'b1;
                cmd.dat = hdr_reg[latmf_pkg::HDR_W-1];
                if (cmd_ready) begin
                    hdr_next = {hdr_reg[latmf_pkg::HDR_W-2:0], 1'b0};
                    if (bcnt_reg == 7'd0) begin
                        byte_next  = (runs_reg != '0) ? latmf_pkg::PLI_RUN_BYTE :
                                     rmd_reg[7:0];
                        bcnt_next  = 7'd7;
                        state_next = ST_PLI;
                    end else begin
                        bcnt_next = bcnt_reg - 7'd1;
                    end
                end
            end
            ST_PLI: begin
                cmd.vld = 1'b1;
                cmd.dat = byte_reg[7];
                if (cmd_ready) begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    if (bcnt_reg == 7'd0) begin
                        bcnt_next = 7'd7;
                        if (runs_reg == '0) begin
                            byte_next  = data_reg;
                            state_next = ST_DATA;
                        end else begin
                            runs_next = runs_reg - 1'b1;
                            byte_next = (runs_reg != 1) ? latmf_pkg::PLI_RUN_BYTE :
                                        rmd_reg[7:0];
                        end
                    end else begin
                        bcnt_next = bcnt_reg - 7'd1;
                    end
                end
            end
            ST_DATA: begin
                cmd.vld  = 1'b1;
                cmd.dat  = byte_reg[7];
                cmd.mark = (rem_reg != 12'd0);
                if (cmd_ready) begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    if (bcnt_reg == 7'd0) begin
                        state_next = (rem_reg == 12'd0) ? ST_FLUSH : ST_IDLE;
                    end else begin
                        bcnt_next = bcnt_reg - 7'd1;
                    end
                end
            end
            ST_FLUSH: begin
                cmd.vld   = 1'b1;
                cmd.flush = 1'b1;
                if (cmd_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rem_reg   <= 12'd0;
            runs_reg  <= '0;
            bcnt_reg  <= 7'd0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            runs_reg  <= runs_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rmd_reg  <= rmd_next;
        hdr_reg  <= hdr_next;
        byte_reg <= byte_next;
        data_reg <= data_next;
    end

    a_pli_remainder_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PLI |-> rmd_reg < latmf_pkg::PLI_RUN)
        else $error("length remainder not reduced below 255");

    a_flush_only_at_unit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH |-> rem_reg == 12'd0)
        else $error("padding before end of unit");

    a_new_unit_starts_header: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && rem_reg == 12'd0 |=> state_reg == ST_DIV)
        else $error("first byte of unit did not start a header");

endmodule

/* sv/latm_audio_unit_framer.sv */
// ----------------------------------------------------------------------------
// latm_audio_unit_framer: LOAS/LATM AudioSyncStream framer
// Wraps AAC audio units, one byte per transfer, into LATM frames with header,
// AudioSpecificConfig, PayloadLengthInfo and bit-shifted payload.
//
//   channel | ports                          | item
//   --------+--------------------------------+-------------------------------
//   input   | s_valid s_ready s_data         | data_byte, au_length
//   output  | m_valid m_ready m_data         | out_byte, frame_end, run_end
//   config  | psel penable pwrite paddr ...  | 4 registers at 4*index
//
// A payload byte inside a unit is accepted, then sent as its eight bits.
// The first byte of a unit also passes the run division (one subtraction
// per 255-run), the header load, 69 (AAC-LC) or 78 (SBR) header bits and
// the PayloadLengthInfo bytes; the last byte of a unit adds a pad request.
// A bit that completes a byte waits while the output register is still full.
// Reset is synchronous and clears control and config registers only.
// ----------------------------------------------------------------------------
module latm_audio_unit_framer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  latmf_pkg::in_item_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output latmf_pkg::out_item_t            m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [latmf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    latmf_pkg::cfg_t     cfg_reg, cfg_next;
    latmf_pkg::bit_cmd_t cmd;
    logic                cmd_ready;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                latmf_pkg::REG_SBR_ENABLED: cfg_next.sbr_enabled          = pwdata[0];
                latmf_pkg::REG_CORE_RATE:   cfg_next.core_rate_index      = pwdata[3:0];
                latmf_pkg::REG_CHANNEL_CFG: cfg_next.channel_config       = pwdata[3:0];
                latmf_pkg::REG_EXT_RATE:    cfg_next.extension_rate_index = pwdata[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            latmf_pkg::REG_SBR_ENABLED: prdata = {31'd0, cfg_reg.sbr_enabled};
            latmf_pkg::REG_CORE_RATE:   prdata = {28'd0, cfg_reg.core_rate_index};
            latmf_pkg::REG_CHANNEL_CFG: prdata = {28'd0, cfg_reg.channel_config};
            latmf_pkg::REG_EXT_RATE:    prdata = {28'd0, cfg_reg.extension_rate_index};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= latmf_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    latmf_bit_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    latmf_byte_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
